// File: sv/mt_pkg.sv
package mt_pkg;

  localparam int STATE_WORDS      = 624;
  localparam int KEY_WORDS_DEF    = 8;
  localparam int TWIST_OFFSET     = 397;
  localparam int STATE_IDX_W      = 10;

  // Command codes as seen on the input channel.
  localparam logic [1:0] CMD_DRAW     = 2'd0;
  localparam logic [1:0] CMD_SEED_WORD = 2'd1;
  localparam logic [1:0] CMD_KEY_WRITE = 2'd2;
  localparam logic [1:0] CMD_SEED_KEYS = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
    logic [2:0]  key_index;
  } mt_cmd_t;

endpackage

// File: sv/mt_front.sv
module mt_front import mt_pkg::*; #(
  parameter int KeyWords = KEY_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_key_index,
  output logic        q_valid,
  output mt_cmd_t     q_item,
  input  logic        q_pop
);

  // two-entry queue of classified commands
  mt_cmd_t     q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        accept, keep, push, pop;

  assign in_stall = (count_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  // key writes beyond the key store are dropped here
  assign keep     = !((in_cmd == CMD_KEY_WRITE) && (int'(in_key_index) >= KeyWords));
  assign push     = accept && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{op: in_cmd, word: in_word, key_index: in_key_index};
    end
  end

endmodule

// File: sv/mt_back.sv
module mt_back import mt_pkg::*; #(
  parameter int KeyWords = KEY_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  mt_cmd_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value
);

  localparam int KIW = (KeyWords > 1) ? $clog2(KeyWords) : 1;
  localparam int IW  = STATE_IDX_W;
  localparam logic [IW-1:0] LAST  = IW'(STATE_WORDS - 1);
  localparam logic [IW-1:0] FULL  = IW'(STATE_WORDS);
  localparam logic [IW-1:0] OFS   = IW'(TWIST_OFFSET);
  localparam logic [IW-1:0] K1LEN = IW'((STATE_WORDS > KeyWords) ? STATE_WORDS : KeyWords);
  localparam logic [KIW-1:0] JLAST = KIW'(KeyWords - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRD   = 4'd1;
  localparam logic [3:0] S_DOUT  = 4'd2;
  localparam logic [3:0] S_GINIT = 4'd3;
  localparam logic [3:0] S_GLD   = 4'd4;
  localparam logic [3:0] S_GRD   = 4'd5;
  localparam logic [3:0] S_GWR   = 4'd6;
  localparam logic [3:0] S_W0    = 4'd7;
  localparam logic [3:0] S_WMUL  = 4'd8;
  localparam logic [3:0] S_WWR   = 4'd9;
  localparam logic [3:0] S_KRD   = 4'd10;
  localparam logic [3:0] S_KWR   = 4'd11;
  localparam logic [3:0] S_KWRAP = 4'd12;
  localparam logic [3:0] S_KEND  = 4'd13;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] fold30(input logic [31:0] x);
    return x ^ (x >> 30);
  endfunction

  logic [31:0]   tw_mem [STATE_WORDS];
  logic [31:0]   key_r  [KeyWords];

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] a1_r, a1_nxt;
  logic [IW-1:0] a397_r, a397_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [KIW-1:0] j_r, j_nxt;
  logic          loop2_r, loop2_nxt;
  logic          keys_r, keys_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_value_r, out_value_nxt;
  logic [31:0]   key_word_r;

  logic          we, rd_en;
  logic [IW-1:0] waddr, ra_addr, rb_addr;
  logic [31:0]   wdata, rda_q, rdb_q;
  logic          key_we;
  logic [31:0]   mul_a, mul_b, mul_lo, y, val;
  logic          out_free;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign mul_lo    = 32'(mul_a * mul_b);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    a1_nxt        = a1_r;
    a397_nxt      = a397_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    loop2_nxt     = loop2_r;
    keys_nxt      = keys_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    q_pop         = 1'b0;
    key_we        = 1'b0;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = 32'd0;
    rd_en         = 1'b0;
    ra_addr       = idx_r;
    rb_addr       = a397_r;
    mul_a         = fold30(prev_r);
    mul_b         = 32'd1812433253;
    y             = {cur_r[31], rda_q[30:0]};
    val           = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          seed_nxt = q_item.word;
          unique case (q_item.op)
            CMD_DRAW:      state_nxt = S_DRD;
            CMD_SEED_WORD: begin
              keys_nxt  = 1'b0;
              state_nxt = S_W0;
            end
            CMD_KEY_WRITE: key_we = 1'b1;
            CMD_SEED_KEYS: begin
              keys_nxt  = 1'b1;
              seed_nxt  = 32'd19650218;
              state_nxt = S_W0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DRD: begin
        if (pos_r >= FULL) begin
          state_nxt = S_GINIT;
        end else begin
          rd_en     = 1'b1;
          ra_addr   = pos_r;
          state_nxt = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = temper(rda_q);
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GINIT: begin
        rd_en     = 1'b1;
        ra_addr   = '0;
        idx_nxt   = '0;
        a1_nxt    = IW'(1);
        a397_nxt  = OFS;
        state_nxt = S_GLD;
      end
      S_GLD: begin
        cur_nxt   = rda_q;
        state_nxt = S_GRD;
      end
      S_GRD: begin
        rd_en     = 1'b1;
        ra_addr   = a1_r;
        rb_addr   = a397_r;
        state_nxt = S_GWR;
      end
      S_GWR: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = rdb_q ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'd0);
        cur_nxt = rda_q;
        if (idx_r == LAST) begin
          pos_nxt   = '0;
          state_nxt = S_DRD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          a1_nxt    = (a1_r == LAST) ? '0 : a1_r + 1'b1;
          a397_nxt  = (a397_r == LAST) ? '0 : a397_r + 1'b1;
          state_nxt = S_GRD;
        end
      end
      S_W0: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = seed_r;
        prev_nxt  = seed_r;
        idx_nxt   = IW'(1);
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        prod_nxt  = mul_lo;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        val      = prod_r + {22'd0, idx_r};
        we       = 1'b1;
        waddr    = idx_r;
        wdata    = val;
        prev_nxt = val;
        if (idx_r == LAST) begin
          pos_nxt = FULL;
          if (keys_r) begin
            // key mixing starts at word 1, whose predecessor is the seed word
            prev_nxt  = seed_r;
            idx_nxt   = IW'(1);
            j_nxt     = '0;
            k_nxt     = K1LEN;
            loop2_nxt = 1'b0;
            state_nxt = S_KRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_WMUL;
        end
      end
      S_KRD: begin
        rd_en     = 1'b1;
        ra_addr   = idx_r;
        mul_b     = loop2_r ? 32'd1566083941 : 32'd1664525;
        prod_nxt  = mul_lo;
        state_nxt = S_KWR;
      end
      S_KWR: begin
        if (loop2_r) begin
          val = (rda_q ^ prod_r) - {22'd0, idx_r};
        end else begin
          val   = (rda_q ^ prod_r) + key_word_r + 32'(j_r);
          j_nxt = (j_r == JLAST) ? '0 : j_r + 1'b1;
        end
        we       = 1'b1;
        waddr    = idx_r;
        wdata    = val;
        prev_nxt = val;
        if (k_r == IW'(1)) begin
          if (!loop2_r) begin
            loop2_nxt = 1'b1;
            k_nxt     = LAST;
          end else begin
            k_nxt = '0;
          end
        end else begin
          k_nxt = k_r - 1'b1;
        end
        if (idx_r == LAST) begin
          idx_nxt   = IW'(1);
          state_nxt = S_KWRAP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (loop2_r && k_r == IW'(1)) ? S_KEND : S_KRD;
        end
      end
      S_KWRAP: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = prev_r;
        state_nxt = (loop2_r && k_r == '0) ? S_KEND : S_KRD;
      end
      S_KEND: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = 32'h80000000;
        pos_nxt   = FULL;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= FULL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    a1_r        <= a1_nxt;
    a397_r      <= a397_nxt;
    k_r         <= k_nxt;
    j_r         <= j_nxt;
    loop2_r     <= loop2_nxt;
    keys_r      <= keys_nxt;
    seed_r      <= seed_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
  end

  // twister store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      tw_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rda_q <= tw_mem[ra_addr];
      rdb_q <= tw_mem[rb_addr];
    end
  end

  // key store: registered read, ready by the write step of each key word
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r[KIW'(q_item.key_index)] <= q_item.word;
    end
    key_word_r <= key_r[j_r];
  end

endmodule

// File: sv/mt19937_generator.sv
// MT19937 random word generator.
// Input channel (in_valid / in_stall): one beat carries a command in in_cmd,
// a word and a key index. Draw yields one tempered word on the result channel;
// seed from word, key write and seed from key store yield nothing.
// A key write whose index lies beyond the key store is dropped on entry.
// Commands go through a two-entry queue, so in_stall rises only when the
// queue is full while the sequencer is busy with earlier commands.
// Steps per command, once it leaves the queue:
//   draw: a read of the store, then the tempered word, one draw at a time; when the store is
//     used up, a regeneration of all 624 words comes first (every 624 draws from a seed).
//   seed from word: word 0, then a multiply step and a write step for each further word.
//   key write: stored in the key store as it leaves the queue.
//   seed from key store: the word seed, then a read step and a write step a word over
//     max(624,KEY_WORDS) + 623 words, a wrap step at each wrap, and a closing step.
// Speed is set by the single write port of the 624-word store and, in the
// seeds, by the multiplier step feeding each word.
// The result sits in an output register; while out_stall is high it holds,
// and the back end waits before loading a further word.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and leaves the store unseeded; a draw before any seed gives no defined word.
module mt19937_generator import mt_pkg::*; #(
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_key_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value
);

  logic    q_valid;
  logic    q_pop;
  mt_cmd_t q_item;

  // front: accept beats, drop out-of-range key writes, queue the rest
  mt_front #(.KeyWords(KEY_WORDS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_word      (in_word),
    .in_key_index (in_key_index),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // back: sequencer over the twister store and key store
  mt_back #(.KeyWords(KEY_WORDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

endmodule

// File: sv/mt_checker.sv
module mt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic [31:0] in_word,
  input logic [2:0]  in_key_index,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value
);

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_word)
      && $stable(in_key_index))
    else $error("stalled command changed");

  a_no_early_out: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid)
    else $error("result before any draw");

endmodule

bind mt19937_generator mt_checker u_mt_checker (.*);
